/* hdl/deq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg - shared types and constants of the double-ended queue
// Command and status codes, field widths and the default queue depth.
// ----------------------------------------------------------------------------

package deq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 1024;
   localparam int unsigned WORD_WIDTH    = 32;
   localparam int unsigned COUNT_WIDTH   = 11;
   localparam int unsigned CMD_WIDTH     = 3;
   localparam int unsigned STATUS_WIDTH  = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH_TAIL = 3'd0,
      CMD_PUSH_HEAD = 3'd1,
      CMD_POP_HEAD  = 3'd2,
      CMD_POP_TAIL  = 3'd3,
      CMD_PEEK_HEAD = 3'd4,
      CMD_PEEK_TAIL = 3'd5,
      CMD_SIZE      = 3'd6,
      CMD_CLEAR     = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_WORD  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

endpackage

`default_nettype wire

/* hdl/deq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram - word store of the double-ended queue
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------

module deq_ram #(
   parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [AddrW-1:0]                wr_addr,
   input  wire logic [deq_pkg::WORD_WIDTH-1:0]  wr_data,
   input  wire logic                            rd_en,
   input  wire logic [AddrW-1:0]                rd_addr,
   output      logic [deq_pkg::WORD_WIDTH-1:0]  rd_data
);

   logic [deq_pkg::WORD_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/double_ended_queue_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit - double-ended queue of signed 32-bit words
// Ring buffer in one synchronous memory with head, tail and occupancy
// registers; push, pop and peek at either end, size read and clear.
// ----------------------------------------------------------------------------
//
//  channel  dir  width  beat contents (lowest bit first)
//  req_     in   40     cmd[2:0], value[34:3], zero pad
//  rsp_     out  48     status[1:0], word[33:2], count[44:34], zero pad
//
// one command per cycle when the response side keeps up; a response
// passes the memory read, then the output register. pointers and
// occupancy move as the command is taken, so back-to-back commands see
// each other at once. reset clears pointers, occupancy and both stage
// valid flags, not the memory. a stalled response holds the middle
// stage, which in turn holds the request side.
// ----------------------------------------------------------------------------

module double_ended_queue_unit #(
   parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // cmd[2:0], value[34:3]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata    // status[1:0], word[33:2], count[44:34]
);

   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned OccW  = $clog2(DEPTH + 1);
   localparam int unsigned WordW = deq_pkg::WORD_WIDTH;
   localparam int unsigned CntW  = deq_pkg::COUNT_WIDTH;

   // request fields
   deq_pkg::cmd_type    req_cmd;
   logic [WordW-1:0]    req_value;

   // queue state
   logic [AddrW-1:0]    head_ff, head_in;
   logic [AddrW-1:0]    tail_ff, tail_in;
   logic [OccW-1:0]     occ_ff, occ_in;

   // stage 0 decode
   logic                 accept;
   logic                 q_empty, q_full;
   logic [AddrW-1:0]     head_next, head_prev, tail_next, tail_prev;
   logic                 wr_en, rd_en;
   logic [AddrW-1:0]     wr_addr, rd_addr;
   deq_pkg::status_type  s0_status;
   logic [CntW-1:0]      s0_count;

   // stage 1: waiting for memory read data
   logic                 s1_valid_ff, s1_valid_in;
   deq_pkg::status_type  s1_status_ff;
   logic                 s1_use_ram_ff;
   logic [CntW-1:0]      s1_count_ff;
   logic                 s1_adv;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   deq_pkg::status_type  rsp_status_ff;
   logic [WordW-1:0]     rsp_word_ff;
   logic [CntW-1:0]      rsp_count_ff;

   logic [WordW-1:0]     ram_rd_data;
   logic [OccW-1:0]      ptr_dist;

   assign req_cmd   = deq_pkg::cmd_type'(req_tdata[2:0]);
   assign req_value = req_tdata[34:3];

   // handshakes
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign q_empty = (occ_ff == '0);
   assign q_full  = (occ_ff == OccW'(DEPTH));

   // wrapping neighbours of the two pointers
   assign head_next = (head_ff == AddrW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? AddrW'(DEPTH - 1) : head_ff - 1'b1;
   assign tail_next = (tail_ff == AddrW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? AddrW'(DEPTH - 1) : tail_ff - 1'b1;

   // stage 0: command decode, pointer update and memory access
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      s0_status = deq_pkg::ST_OK;
      case (req_cmd)
         deq_pkg::CMD_PUSH_TAIL: begin
            if (q_full) begin
               s0_status = deq_pkg::ST_FULL;
            end else begin
               wr_en   = accept;
               wr_addr = tail_ff;
               tail_in = tail_next;
               occ_in  = occ_ff + 1'b1;
            end
         end
         deq_pkg::CMD_PUSH_HEAD: begin
            if (q_full) begin
               s0_status = deq_pkg::ST_FULL;
            end else begin
               wr_en   = accept;
               wr_addr = head_prev;
               head_in = head_prev;
               occ_in  = occ_ff + 1'b1;
            end
         end
         deq_pkg::CMD_POP_HEAD: begin
            if (q_empty) begin
               s0_status = deq_pkg::ST_EMPTY;
            end else begin
               s0_status = deq_pkg::ST_WORD;
               rd_en     = accept;
               rd_addr   = head_ff;
               head_in   = head_next;
               occ_in    = occ_ff - 1'b1;
            end
         end
         deq_pkg::CMD_POP_TAIL: begin
            if (q_empty) begin
               s0_status = deq_pkg::ST_EMPTY;
            end else begin
               s0_status = deq_pkg::ST_WORD;
               rd_en     = accept;
               rd_addr   = tail_prev;
               tail_in   = tail_prev;
               occ_in    = occ_ff - 1'b1;
            end
         end
         deq_pkg::CMD_PEEK_HEAD: begin
            if (q_empty) begin
               s0_status = deq_pkg::ST_EMPTY;
            end else begin
               s0_status = deq_pkg::ST_WORD;
               rd_en     = accept;
               rd_addr   = head_ff;
            end
         end
         deq_pkg::CMD_PEEK_TAIL: begin
            if (q_empty) begin
               s0_status = deq_pkg::ST_EMPTY;
            end else begin
               s0_status = deq_pkg::ST_WORD;
               rd_en     = accept;
               rd_addr   = tail_prev;
            end
         end
         deq_pkg::CMD_SIZE: begin
            s0_status = deq_pkg::ST_OK;
         end
         deq_pkg::CMD_CLEAR: begin
            head_in = '0;
            tail_in = '0;
            occ_in  = '0;
         end
         default: begin
            s0_status = deq_pkg::ST_OK;
         end
      endcase
   end

   // reported count is the occupancy after the command, cut or zero-extended to the field width
   generate
      if (OccW >= CntW) begin : g_cnt_cut
         assign s0_count = occ_in[CntW-1:0];
      end else begin : g_cnt_ext
         assign s0_count = {{(CntW - OccW){1'b0}}, occ_in};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (accept) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   deq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // stage 1: the memory read completes here
   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff  <= s0_status;
         s1_use_ram_ff <= (s0_status == deq_pkg::ST_WORD);
         s1_count_ff   <= s0_count;
      end
   end

   // response register
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_status_ff <= s1_status_ff;
         rsp_word_ff   <= s1_use_ram_ff ? ram_rd_data : '0;
         rsp_count_ff  <= s1_count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_word_ff, rsp_status_ff};

   // distance from head to tail around the ring
   always_comb begin
      if (tail_ff >= head_ff) begin
         ptr_dist = OccW'(tail_ff) - OccW'(head_ff);
      end else begin
         ptr_dist = OccW'(tail_ff) + OccW'(DEPTH) - OccW'(head_ff);
      end
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OccW'(DEPTH))
      else $error("occupancy above depth");

   a_ptr_occ : assert property (@(posedge clock) disable iff (reset)
      (occ_ff == OccW'(DEPTH)) || (ptr_dist == occ_ff))
      else $error("pointers disagree with occupancy");

   a_rd_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_use_ram_ff && !s1_adv) |=> $stable(ram_rd_data))
      else $error("read data lost while stage 1 stalled");

   a_word_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != deq_pkg::ST_WORD)) |-> (rsp_word_ff == '0))
      else $error("word not zero on a non-word response");

   a_no_access_idle : assert property (@(posedge clock) disable iff (reset)
      !accept |-> (!wr_en && !rd_en))
      else $error("memory access without an accepted command");

endmodule

`default_nettype wire
